// ===== hdl/nps_pkg.sv =====
`timescale 1ns / 1ps

package nps_pkg;

   // default palette depth
   localparam int unsigned NPS_PALETTE_ENTRIES = 256;

   localparam int unsigned LEVEL_W      = 6;
   localparam int unsigned QUERY_W      = 5;
   localparam int unsigned SQUARE_W     = 2 * LEVEL_W;
   localparam int unsigned DIST_W       = 14;
   localparam int unsigned ENTRY_IDX_W  = 8;

   // request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [LEVEL_W-1:0]     entry_red;
      logic [LEVEL_W-1:0]     entry_green;
      logic [LEVEL_W-1:0]     entry_blue;
      logic [QUERY_W-1:0]     query_red;
      logic [QUERY_W-1:0]     query_green;
      logic [QUERY_W-1:0]     query_blue;
   } req_item_type;

   typedef struct packed {
      logic [ENTRY_IDX_W-1:0] nearest_index;
      logic [DIST_W-1:0]      best_distance;
   } rsp_item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } colour_type;

   // what travels from one cell to the next, besides the winning index
   typedef struct packed {
      logic              valid;
      colour_type        query;
      logic [DIST_W-1:0] distance;
   } chain_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN
   } nps_state_type;

   // square of the absolute difference of two levels
   function automatic logic [SQUARE_W-1:0] sq_diff(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
      logic [LEVEL_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQUARE_W'(d) * SQUARE_W'(d);
   endfunction

endpackage

// ===== hdl/nps_cell.sv =====
`timescale 1ns / 1ps

module nps_cell import nps_pkg::*; #(
   parameter int unsigned IDX_W   = 8,
   parameter int unsigned CELL_ID = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  colour_type       wr_entry,
   input  chain_type        chain_in,
   input  logic [IDX_W-1:0] idx_in,
   output chain_type        chain_out,
   output logic [IDX_W-1:0] idx_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);
   localparam bit FIRST_CELL = (CELL_ID == 0);

   colour_type        entry_ff;
   logic              valid_ff;
   colour_type        query_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] dist_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in_sel;
   logic [DIST_W-1:0] my_dist;
   logic              take;

   // stored palette entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   // distance from this entry to the passing query
   always_comb begin
      my_dist = DIST_W'(sq_diff(entry_ff.red,   chain_in.query.red))
              + DIST_W'(sq_diff(entry_ff.green, chain_in.query.green))
              + DIST_W'(sq_diff(entry_ff.blue,  chain_in.query.blue));
      take = FIRST_CELL ? 1'b1 : (my_dist < chain_in.distance);
      dist_in    = take ? my_dist : chain_in.distance;
      idx_in_sel = take ? MY_IDX : idx_in;
   end

   // hand the query and best match on to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chain_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= chain_in.query;
      dist_ff  <= dist_in;
      idx_ff   <= idx_in_sel;
   end

   assign chain_out.valid    = valid_ff;
   assign chain_out.query    = query_ff;
   assign chain_out.distance = dist_ff;
   assign idx_out            = idx_ff;

endmodule

// ===== hdl/nearest_palette_colour_search_top.sv =====
`timescale 1ns / 1ps
// A palette write is stored in its cell and gives no result; another item may follow at once.
// A query passes one cell per cycle through a row of PALETTE_ENTRIES cells, each
// holding one entry; at the tail its result is registered in the output register,
// or in a hold register while the output register is still full. One query is in the
// row at a time: no new request is accepted until its result has reached the output register.
// Reset clears the control state only; palette contents are undefined until written.

module nearest_palette_colour_search_top import nps_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = NPS_PALETTE_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

   nps_state_type     state_ff;
   nps_state_type     state_in;
   logic              req_fire;
   logic              write_fire;
   logic              query_fire;
   logic              slot_free;
   logic              tail_to_rsp;
   logic              hold_to_rsp;
   logic              tail_to_hold;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_item_ff;
   rsp_item_type      hold_ff;
   rsp_item_type      tail_item;
   colour_type        wr_entry;
   chain_type         chain [0:PALETTE_ENTRIES];
   logic [IDX_W-1:0]  idx   [0:PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] cell_we;

   assign req_fire   = req_valid && req_ready;
   assign write_fire = req_fire && (req_item.req_type == REQ_WRITE);
   assign query_fire = req_fire && (req_item.req_type == REQ_QUERY);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // query enters the head of the row with its channels doubled
   assign chain[0].valid       = query_fire;
   assign chain[0].query.red   = {req_item.query_red,   1'b0};
   assign chain[0].query.green = {req_item.query_green, 1'b0};
   assign chain[0].query.blue  = {req_item.query_blue,  1'b0};
   assign chain[0].distance    = '0;
   assign idx[0]               = '0;

   assign wr_entry.red   = req_item.entry_red;
   assign wr_entry.green = req_item.entry_green;
   assign wr_entry.blue  = req_item.entry_blue;

   // row of cells, one palette entry each
   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      localparam int unsigned ID = i;
      if (ID < (1 << ENTRY_IDX_W)) begin : g_we
         assign cell_we[i] = write_fire && (req_item.entry_index == ENTRY_IDX_W'(ID));
      end else begin : g_no_we
         assign cell_we[i] = 1'b0;
      end

      nps_cell #(
         .IDX_W   (IDX_W),
         .CELL_ID (ID)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (cell_we[i]),
         .wr_entry  (wr_entry),
         .chain_in  (chain[i]),
         .idx_in    (idx[i]),
         .chain_out (chain[i+1]),
         .idx_out   (idx[i+1])
      );
   end

   assign tail_item.nearest_index = ENTRY_IDX_W'(idx[PALETTE_ENTRIES]);
   assign tail_item.best_distance = chain[PALETTE_ENTRIES].distance;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (chain[PALETTE_ENTRIES].valid) begin
               state_in = slot_free ? ST_IDLE : ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_ready    = 1'b0;
      tail_to_rsp  = 1'b0;
      tail_to_hold = 1'b0;
      hold_to_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SEARCH: begin
            tail_to_rsp  = chain[PALETTE_ENTRIES].valid && slot_free;
            tail_to_hold = chain[PALETTE_ENTRIES].valid && !slot_free;
         end
         ST_DRAIN: begin
            hold_to_rsp = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result waiting for the output slot
   always_ff @(posedge clock) begin
      if (tail_to_hold) begin
         hold_ff <= tail_item;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tail_to_rsp || hold_to_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_to_rsp) begin
         rsp_item_ff <= tail_item;
      end else if (hold_to_rsp) begin
         rsp_item_ff <= hold_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
